// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; take in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lpg_pkg.sv =====
// Shared types and constants of the line pixel generator.
// No dependencies; used by the interfaces, the top level and the checker.
package lpg_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CLIP_BITS    = 12;
    localparam int COLOR_BITS   = 32;
    localparam int ERR_BITS     = COORD_BITS + 1;
    localparam int CMP_BITS     = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;
    localparam int CFG_IDX_BITS = 1;

    typedef enum logic {
        REQ_LOAD    = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req_type;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HEIGHT = 1'd1;

    localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RST  = 12'd320;
    localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RST = 12'd240;

    // Step direction codes
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef struct packed {
        t_req_type                      req_type;
        logic signed [COORD_BITS-1:0]   x_start;
        logic signed [COORD_BITS-1:0]   y_start;
        logic signed [COORD_BITS-1:0]   x_end;
        logic signed [COORD_BITS-1:0]   y_end;
        logic        [COLOR_BITS-1:0]   line_color;
    } t_req;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]   pixel_x;
        logic signed [COORD_BITS-1:0]   pixel_y;
        logic        [COLOR_BITS-1:0]   pixel_color;
        logic                           in_window;
        logic                           last_pixel;
    } t_pix;

endpackage

// ===== sv/lpg_req_if.sv =====
// Request channel: load and advance beats into the line pixel generator.
// Depends on lpg_pkg.
interface lpg_req_if;
    logic          valid;
    logic          ready;
    lpg_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/lpg_pix_if.sv =====
// Pixel channel: one beat per emitted line pixel.
// Depends on lpg_pkg.
interface lpg_pix_if;
    logic          valid;
    logic          ready;
    lpg_pkg::t_pix payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/line_pixel_generator.sv =====
// Bresenham line rasteriser. An accepted advance beat passes through the input register,
// then the result register, before its pixel shows on the output.
// Throughput: one request beat per cycle, one pixel per cycle while the sink takes them.
// Reset (synchronous, active low) drops any loaded line, empties both registers and
// restores the clip window to 320 x 240.
module line_pixel_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lpg_req_if.sink                             i_req,
    lpg_pix_if.source                           o_pix,
    input  logic                                i_cfg_we,
    input  logic [lpg_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lpg_pkg::CLIP_BITS-1:0]       i_cfg_data
);

    localparam int CB = lpg_pkg::COORD_BITS;

    // Configuration
    logic [lpg_pkg::CLIP_BITS-1:0] r_clip_width;
    logic [lpg_pkg::CLIP_BITS-1:0] r_clip_height;

    // Input register
    logic           r_s1_valid;
    lpg_pkg::t_req  r_s1;

    // Line state
    logic                       r_line_active;
    logic                       r_x_is_major;
    logic [CB-1:0]              r_pos_x;
    logic [CB-1:0]              r_pos_y;
    logic [CB-1:0]              r_stop_x;
    logic [CB-1:0]              r_stop_y;
    logic [CB-1:0]              r_major_delta;
    logic [CB-1:0]              r_minor_delta;
    logic [lpg_pkg::ERR_BITS-1:0] r_error_acc;
    logic [1:0]                 r_dir_x;
    logic [1:0]                 r_dir_y;
    logic [lpg_pkg::COLOR_BITS-1:0] r_held_color;

    // Result register
    logic           r_out_valid;
    lpg_pkg::t_pix  r_out;

    // Handshake
    logic s1_is_load;
    logic s1_emits;
    logic out_free;
    logic s1_fire;

    // Load set-up
    logic [CB:0]    dx;
    logic [CB:0]    dy;
    logic [CB:0]    neg_dx;
    logic [CB:0]    neg_dy;
    logic [CB-1:0]  adx;
    logic [CB-1:0]  ady;
    logic [1:0]     n_dir_x;
    logic [1:0]     n_dir_y;
    logic           n_x_is_major;
    logic [CB-1:0]  n_major_delta;
    logic [CB-1:0]  n_minor_delta;

    // Step
    logic                           last;
    logic                           in_win;
    logic [lpg_pkg::ERR_BITS-1:0]   err_sum;
    logic                           minor_step;
    logic [lpg_pkg::ERR_BITS-1:0]   n_error_acc;
    logic [CB-1:0]                  step_x;
    logic [CB-1:0]                  step_y;
    logic [CB-1:0]                  n_pos_x;
    logic [CB-1:0]                  n_pos_y;

    always_comb begin
        s1_is_load = (r_s1.req_type == lpg_pkg::REQ_LOAD);
        s1_emits   = r_s1_valid && !s1_is_load && r_line_active;
        out_free   = !r_out_valid || o_pix.ready;
        s1_fire    = r_s1_valid && (!s1_emits || out_free);
    end

    assign i_req.ready = !r_s1_valid || s1_fire;
    assign o_pix.valid   = r_out_valid;
    assign o_pix.payload = r_out;

    // Deltas, magnitudes and directions of a new line
    always_comb begin
        dx     = {r_s1.x_end[CB-1], r_s1.x_end} - {r_s1.x_start[CB-1], r_s1.x_start};
        dy     = {r_s1.y_end[CB-1], r_s1.y_end} - {r_s1.y_start[CB-1], r_s1.y_start};
        neg_dx = ~dx + 1'b1;
        neg_dy = ~dy + 1'b1;
        adx    = dx[CB] ? neg_dx[CB-1:0] : dx[CB-1:0];
        ady    = dy[CB] ? neg_dy[CB-1:0] : dy[CB-1:0];
        priority if (dx == '0) begin
            n_dir_x = lpg_pkg::DIR_NONE;
        end else if (dx[CB]) begin
            n_dir_x = lpg_pkg::DIR_NEG;
        end else begin
            n_dir_x = lpg_pkg::DIR_POS;
        end
        priority if (dy == '0) begin
            n_dir_y = lpg_pkg::DIR_NONE;
        end else if (dy[CB]) begin
            n_dir_y = lpg_pkg::DIR_NEG;
        end else begin
            n_dir_y = lpg_pkg::DIR_POS;
        end
        // Equal deltas fall to y as the major axis
        n_x_is_major  = ady < adx;
        n_major_delta = n_x_is_major ? adx : ady;
        n_minor_delta = n_x_is_major ? ady : adx;
    end

    // One Bresenham step from the current position
    always_comb begin
        last   = r_x_is_major ? (r_pos_x == r_stop_x) : (r_pos_y == r_stop_y);
        in_win = !r_pos_x[CB-1] && !r_pos_y[CB-1]
              && (lpg_pkg::CMP_BITS'(r_pos_x) < lpg_pkg::CMP_BITS'(r_clip_width))
              && (lpg_pkg::CMP_BITS'(r_pos_y) < lpg_pkg::CMP_BITS'(r_clip_height));
        err_sum     = r_error_acc + {1'b0, r_minor_delta};
        minor_step  = err_sum > {1'b0, r_major_delta};
        n_error_acc = minor_step ? (err_sum - {1'b0, r_major_delta}) : err_sum;
        step_x  = r_pos_x + {{(CB-2){r_dir_x[1]}}, r_dir_x};
        step_y  = r_pos_y + {{(CB-2){r_dir_y[1]}}, r_dir_y};
        n_pos_x = (r_x_is_major || minor_step) ? step_x : r_pos_x;
        n_pos_y = (!r_x_is_major || minor_step) ? step_y : r_pos_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_width  <= lpg_pkg::CLIP_WIDTH_RST;
            r_clip_height <= lpg_pkg::CLIP_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpg_pkg::CFG_CLIP_WIDTH:  r_clip_width  <= i_cfg_data;
                lpg_pkg::CFG_CLIP_HEIGHT: r_clip_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: hold while the step stage stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1 <= i_req.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
        end else if (s1_fire) begin
            if (s1_is_load) begin
                r_line_active <= 1'b1;
            end else if (r_line_active && last) begin
                r_line_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (s1_is_load) begin
                r_pos_x       <= r_s1.x_start;
                r_pos_y       <= r_s1.y_start;
                r_stop_x      <= r_s1.x_end;
                r_stop_y      <= r_s1.y_end;
                r_dir_x       <= n_dir_x;
                r_dir_y       <= n_dir_y;
                r_x_is_major  <= n_x_is_major;
                r_major_delta <= n_major_delta;
                r_minor_delta <= n_minor_delta;
                r_error_acc   <= {2'b00, n_major_delta[CB-1:1]};
                r_held_color  <= r_s1.line_color;
            end else if (r_line_active && !last) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_error_acc <= n_error_acc;
            end
        end
    end

    // Result register: fill on an emitting step, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_emits) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_emits) begin
            r_out.pixel_x     <= r_pos_x;
            r_out.pixel_y     <= r_pos_y;
            r_out.pixel_color <= r_held_color;
            r_out.in_window   <= in_win;
            r_out.last_pixel  <= last;
        end
    end

endmodule

// ===== sv/lpg_checker.sv =====
// Port-level checks of the line pixel generator, bound to the top level.
// Depends on lpg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpg_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  lpg_pkg::t_req   i_req_payload,
    input  logic            i_pix_valid,
    input  logic            i_pix_ready,
    input  lpg_pkg::t_pix   i_pix_payload
);

    logic load_beat;
    assign load_beat = i_req_valid && i_req_ready
                    && (i_req_payload.req_type == lpg_pkg::REQ_LOAD);

    `ASSERT_CLK(a_pix_hold, i_clk, i_rst_n, i_pix_valid && !i_pix_ready |=> $stable(i_pix_payload), "pixel beat changed under stall")
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_pix_valid, "pixel beat shown straight after reset")
    `ASSERT_CLK(a_load_silent, i_clk, i_rst_n, load_beat ##1 !i_pix_valid |=> !i_pix_valid, "load beat produced a pixel")
    `ASSERT_CLK(a_window_sign, i_clk, i_rst_n, i_pix_valid && i_pix_payload.in_window |-> !i_pix_payload.pixel_x[lpg_pkg::COORD_BITS-1] && !i_pix_payload.pixel_y[lpg_pkg::COORD_BITS-1], "negative pixel flagged inside window")

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_payload (i_req.payload),
    .i_pix_valid   (o_pix.valid),
    .i_pix_ready   (o_pix.ready),
    .i_pix_payload (o_pix.payload)
);
